// ===== src/ntp_client_poll_scheduler_core_assert.svh =====
// Assertion macros used by the checker file of the poll scheduler.
`ifndef NTP_CLIENT_POLL_SCHEDULER_CORE_ASSERT_SVH
`define NTP_CLIENT_POLL_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define NCPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define NCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ncps_pkg.sv =====
// Types, codes and constants of the NTP client poll scheduler.
`default_nettype none

package ncps_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_REPLY = 2'd3
    } ncps_action_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SENT      = 3'd1,
        EV_TIMEOUT   = 3'd2,
        EV_TX_FAIL   = 3'd3,
        EV_KISS      = 3'd4,
        EV_MALFORMED = 3'd5,
        EV_SYNCED    = 3'd6,
        EV_IGNORED   = 3'd7
    } ncps_event_t;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SERVER_IP     = 3'd0,
        CFG_POLL_INTERVAL = 3'd1,
        CFG_TIMEOUT       = 3'd2,
        CFG_RETRY_FAST    = 3'd3,
        CFG_RETRY_SLOW    = 3'd4,
        CFG_FAST_LIMIT    = 3'd5
    } ncps_cfg_t;

    localparam int DEF_MIN_REPLY_LEN = 48;
    localparam int DEF_SERVER_PORT   = 123;

    localparam logic [31:0] RST_POLL_INTERVAL = 32'd60000;
    localparam logic [31:0] RST_TIMEOUT       = 32'd2500;
    localparam logic [31:0] RST_RETRY_FAST    = 32'd5000;
    localparam logic [31:0] RST_RETRY_SLOW    = 32'd60000;
    localparam logic [15:0] RST_FAST_LIMIT    = 16'd3;

    localparam logic [31:0] UNIX_OFFSET  = 32'd2208988800;
    localparam logic [15:0] FAIL_MAX     = 16'hFFFF;
    localparam logic [2:0]  MODE_SERVER  = 3'd4;

    // Elapsed seconds are kept as quotient and remainder of elapsed ms by 1000.
    localparam logic [9:0]  MS_LAST      = 10'd999;
    localparam logic [22:0] QUO_AT_WRAP  = 23'd4294967;
    localparam logic [9:0]  REM_AT_WRAP  = 10'd295;

    typedef struct packed {
        ncps_action_t action;
        logic         tx_ready;
        logic [31:0]  remote_ip;
        logic [15:0]  remote_port;
        logic [15:0]  reply_length;
        logic [7:0]   mode_byte;
        logic [7:0]   stratum;
        logic [31:0]  transmit_seconds;
    } ncps_item_t;

    typedef struct packed {
        logic         send_request;
        logic         consumed;
        ncps_event_t  event_res;
        logic [15:0]  fail_count;
        logic         have_time;
        logic [31:0]  epoch_seconds;
        logic [31:0]  round_trip_ms;
    } ncps_result_t;

endpackage

`default_nettype wire

// ===== src/ncps_in_stage.sv =====
// Input register of the poll scheduler: holds one accepted item.
`default_nettype none

module ncps_in_stage
    import ncps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire ncps_item_t in_item,
    input  wire logic       pop,
    output logic            item_valid,
    output ncps_item_t      item
);

    logic       valid_reg;
    logic       valid_next;
    ncps_item_t item_reg;

    assign in_ready   = !valid_reg || pop;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (pop ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== src/ncps_engine.sv =====
// Scheduler state, configuration registers and the per-item decision logic.
`default_nettype none

module ncps_engine
    import ncps_pkg::*;
#(
    parameter int MIN_REPLY_LEN = DEF_MIN_REPLY_LEN,
    parameter int SERVER_PORT   = DEF_SERVER_PORT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step_en,
    input  wire ncps_item_t             item,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    output ncps_result_t                result
);

    logic [31:0] server_ip_reg, server_ip_next;
    logic [31:0] poll_reg, poll_next;
    logic [31:0] timeout_reg, timeout_next;
    logic [31:0] fast_reg, fast_next;
    logic [31:0] slow_reg, slow_next;
    logic [15:0] limit_reg, limit_next;

    logic [31:0] now_reg, now_next;
    logic        enabled_reg, enabled_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [31:0] pend_since_reg, pend_since_next;
    logic [15:0] fails_reg, fails_next;
    logic [31:0] next_due_reg, next_due_next;
    logic [31:0] epoch_base_reg, epoch_base_next;
    logic [22:0] sec_quo_reg, sec_quo_next;
    logic [9:0]  ms_rem_reg, ms_rem_next;
    logic        synced_reg, synced_next;

    logic [31:0] now_tick;
    logic [15:0] fails_inc;
    logic [31:0] backoff_due;
    logic        timed_out;
    logic [31:0] due_diff;
    logic        reply_ok;

    assign now_tick    = now_reg + 32'd1;
    assign fails_inc   = (fails_reg == FAIL_MAX) ? fails_reg : fails_reg + 16'd1;
    assign backoff_due = now_tick + ((fails_inc < limit_reg) ? fast_reg : slow_reg);
    assign timed_out   = (now_tick - pend_since_reg) >= timeout_reg;
    assign due_diff    = now_tick - next_due_reg;

    assign reply_ok = enabled_reg
                   && (item.remote_port == 16'(SERVER_PORT))
                   && (item.reply_length >= 16'(MIN_REPLY_LEN))
                   && ((server_ip_reg == 32'd0) || (item.remote_ip == server_ip_reg))
                   && (item.mode_byte[2:0] == MODE_SERVER);

    always_comb
    begin
        server_ip_next  = server_ip_reg;
        poll_next       = poll_reg;
        timeout_next    = timeout_reg;
        fast_next       = fast_reg;
        slow_next       = slow_reg;
        limit_next      = limit_reg;
        now_next        = now_reg;
        enabled_next    = enabled_reg;
        pend_valid_next = pend_valid_reg;
        pend_since_next = pend_since_reg;
        fails_next      = fails_reg;
        next_due_next   = next_due_reg;
        epoch_base_next = epoch_base_reg;
        sec_quo_next    = sec_quo_reg;
        ms_rem_next     = ms_rem_reg;
        synced_next     = synced_reg;

        result              = '0;
        result.event_res    = EV_NONE;

        if (step_en)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    now_next = now_tick;
                    // The elapsed ms count wraps at 2^32, and its quotient wraps with it.
                    if ((sec_quo_reg == QUO_AT_WRAP) && (ms_rem_reg == REM_AT_WRAP))
                    begin
                        sec_quo_next = '0;
                        ms_rem_next  = '0;
                    end
                    else if (ms_rem_reg == MS_LAST)
                    begin
                        sec_quo_next = sec_quo_reg + 23'd1;
                        ms_rem_next  = '0;
                    end
                    else
                    begin
                        ms_rem_next = ms_rem_reg + 10'd1;
                    end

                    if (enabled_reg && (server_ip_reg != 32'd0))
                    begin
                        if (pend_valid_reg)
                        begin
                            if (timed_out)
                            begin
                                pend_valid_next  = 1'b0;
                                fails_next       = fails_inc;
                                next_due_next    = backoff_due;
                                result.event_res = EV_TIMEOUT;
                            end
                        end
                        else if (!due_diff[31])
                        begin
                            if (item.tx_ready)
                            begin
                                pend_valid_next     = 1'b1;
                                pend_since_next     = now_tick;
                                result.send_request = 1'b1;
                                result.event_res    = EV_SENT;
                            end
                            else
                            begin
                                fails_next       = fails_inc;
                                next_due_next    = backoff_due;
                                result.event_res = EV_TX_FAIL;
                            end
                        end
                    end
                end
                ACT_START:
                begin
                    enabled_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    fails_next      = '0;
                    next_due_next   = now_reg;
                end
                ACT_STOP:
                begin
                    enabled_next    = 1'b0;
                    pend_valid_next = 1'b0;
                end
                ACT_REPLY:
                begin
                    if (!reply_ok)
                    begin
                        result.event_res = EV_IGNORED;
                    end
                    else if (item.stratum == 8'd0)
                    begin
                        result.consumed  = 1'b1;
                        result.event_res = EV_KISS;
                        pend_valid_next  = 1'b0;
                        next_due_next    = now_reg + slow_reg;
                    end
                    else if (item.transmit_seconds <= UNIX_OFFSET)
                    begin
                        result.consumed  = 1'b1;
                        result.event_res = EV_MALFORMED;
                    end
                    else
                    begin
                        result.consumed  = 1'b1;
                        result.event_res = EV_SYNCED;
                        if (pend_valid_reg)
                        begin
                            result.round_trip_ms = now_reg - pend_since_reg;
                        end
                        epoch_base_next = item.transmit_seconds - UNIX_OFFSET;
                        sec_quo_next    = '0;
                        ms_rem_next     = '0;
                        synced_next     = 1'b1;
                        pend_valid_next = 1'b0;
                        fails_next      = '0;
                        next_due_next   = now_reg + poll_reg;
                    end
                end
                default:
                begin
                    result.event_res = EV_NONE;
                end
            endcase
        end
        else if (cfg_we)
        begin
            case (ncps_cfg_t'(cfg_index))
                CFG_SERVER_IP:
                begin
                    // A new server address restarts the schedule.
                    if (cfg_data != server_ip_reg)
                    begin
                        server_ip_next  = cfg_data;
                        pend_valid_next = 1'b0;
                        fails_next      = '0;
                        next_due_next   = now_reg;
                    end
                end
                CFG_POLL_INTERVAL: poll_next    = cfg_data;
                CFG_TIMEOUT:       timeout_next = cfg_data;
                CFG_RETRY_FAST:    fast_next    = cfg_data;
                CFG_RETRY_SLOW:    slow_next    = cfg_data;
                CFG_FAST_LIMIT:    limit_next   = cfg_data[15:0];
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end

        result.fail_count    = fails_next;
        result.have_time     = synced_next;
        result.epoch_seconds = synced_next ? (epoch_base_next + {9'd0, sec_quo_next}) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_ip_reg  <= '0;
            poll_reg       <= RST_POLL_INTERVAL;
            timeout_reg    <= RST_TIMEOUT;
            fast_reg       <= RST_RETRY_FAST;
            slow_reg       <= RST_RETRY_SLOW;
            limit_reg      <= RST_FAST_LIMIT;
            now_reg        <= '0;
            enabled_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_since_reg <= '0;
            fails_reg      <= '0;
            next_due_reg   <= '0;
            epoch_base_reg <= '0;
            sec_quo_reg    <= '0;
            ms_rem_reg     <= '0;
            synced_reg     <= 1'b0;
        end
        else
        begin
            server_ip_reg  <= server_ip_next;
            poll_reg       <= poll_next;
            timeout_reg    <= timeout_next;
            fast_reg       <= fast_next;
            slow_reg       <= slow_next;
            limit_reg      <= limit_next;
            now_reg        <= now_next;
            enabled_reg    <= enabled_next;
            pend_valid_reg <= pend_valid_next;
            pend_since_reg <= pend_since_next;
            fails_reg      <= fails_next;
            next_due_reg   <= next_due_next;
            epoch_base_reg <= epoch_base_next;
            sec_quo_reg    <= sec_quo_next;
            ms_rem_reg     <= ms_rem_next;
            synced_reg     <= synced_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ncps_out_stage.sv =====
// Result register of the poll scheduler with its valid/ready handshake.
`default_nettype none

module ncps_out_stage
    import ncps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire ncps_result_t load_result,
    output logic              can_load,
    output logic              out_valid,
    input  wire logic         out_ready,
    output ncps_result_t      out_result
);

    logic         valid_reg;
    logic         valid_next;
    ncps_result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== src/ntp_client_poll_scheduler_core.sv =====
// Top level of the SNTP client poll scheduler with fast and slow retry backoff.
// Takes one item per clock cycle while the output side keeps taking results: an accepted item
// waits in the input register, is evaluated combinationally against the scheduler state, and
// its result beat appears on the output port in the cycle after evaluation. The pace is set
// only by the output side; while the result register is full and not taken, the input
// register holds one more item. The configuration port is ready whenever the input register
// is empty; write it only while no item is in flight. Elapsed seconds since the last sync are
// counted incrementally per tick, so epoch_seconds costs one add.
`default_nettype none

module ntp_client_poll_scheduler_core
    import ncps_pkg::*;
#(
    parameter int MIN_REPLY_LEN = DEF_MIN_REPLY_LEN,
    parameter int SERVER_PORT   = DEF_SERVER_PORT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             action,
    input  wire logic                   tx_ready,
    input  wire logic [31:0]            remote_ip,
    input  wire logic [15:0]            remote_port,
    input  wire logic [15:0]            reply_length,
    input  wire logic [7:0]             mode_byte,
    input  wire logic [7:0]             stratum,
    input  wire logic [31:0]            transmit_seconds,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        send_request,
    output logic                        consumed,
    output logic [2:0]                  event_res,
    output logic [15:0]                 fail_count,
    output logic                        have_time,
    output logic [31:0]                 epoch_seconds,
    output logic [31:0]                 round_trip_ms
);

    ncps_item_t   in_item;
    ncps_item_t   item;
    logic         item_valid;
    logic         can_load;
    logic         step_en;
    ncps_result_t step_result;
    ncps_result_t res;

    assign in_item.action           = ncps_action_t'(action);
    assign in_item.tx_ready         = tx_ready;
    assign in_item.remote_ip        = remote_ip;
    assign in_item.remote_port      = remote_port;
    assign in_item.reply_length     = reply_length;
    assign in_item.mode_byte        = mode_byte;
    assign in_item.stratum          = stratum;
    assign in_item.transmit_seconds = transmit_seconds;

    assign step_en   = item_valid && can_load;
    // A write is only taken when no item waits, so it never collides with a step.
    assign cfg_ready = !item_valid;

    ncps_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .pop        (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    ncps_engine #(
        .MIN_REPLY_LEN (MIN_REPLY_LEN),
        .SERVER_PORT   (SERVER_PORT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (step_result)
    );

    ncps_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step_en),
        .load_result (step_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (res)
    );

    assign send_request  = res.send_request;
    assign consumed      = res.consumed;
    assign event_res     = res.event_res;
    assign fail_count    = res.fail_count;
    assign have_time     = res.have_time;
    assign epoch_seconds = res.epoch_seconds;
    assign round_trip_ms = res.round_trip_ms;

endmodule

`default_nettype wire

// ===== src/ncps_checker.sv =====
// Port-level assertions for the poll scheduler, bound to its top level.
`default_nettype none

`include "ntp_client_poll_scheduler_core_assert.svh"

module ncps_checker
    import ncps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic                   send_request,
    input  wire logic                   consumed,
    input  wire logic [2:0]             event_res,
    input  wire logic [15:0]            fail_count,
    input  wire logic                   have_time,
    input  wire logic [31:0]            epoch_seconds,
    input  wire logic [31:0]            round_trip_ms
);

    `NCPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(epoch_seconds), "result beat changed while stalled")

    `NCPS_ASSERT_NOW(a_send_is_sent, out_valid, send_request == (event_res == EV_SENT), "send_request disagrees with the event")

    `NCPS_ASSERT_NOW(a_consumed_event, out_valid, consumed == ((event_res == EV_KISS) || (event_res == EV_MALFORMED) || (event_res == EV_SYNCED)), "consumed disagrees with the event")

    `NCPS_ASSERT_NOW(a_sync_state, out_valid && (event_res == EV_SYNCED), have_time && (fail_count == 16'd0), "sync beat without time or with failures")

    `NCPS_ASSERT_NOW(a_rtt_only_sync, out_valid && (event_res != EV_SYNCED), (round_trip_ms == 32'd0) && (have_time || (epoch_seconds == 32'd0)), "round trip or epoch shown out of place")

endmodule

bind ntp_client_poll_scheduler_core ncps_checker u_ncps_checker (.*);

`default_nettype wire
